>>> sv/fqc_pkg.sv
// Package for the FASTQ read and cycle QC block: sizes, command codes,
// character constants and the base classification function. No dependencies.
package fqc_pkg;

   localparam int MaxReadLen = 512;
   localparam int PosW       = $clog2(MaxReadLen);
   localparam int RpW        = PosW + 1;
   localparam int TblWords   = 11;
   localparam int ReadWords  = 12;
   localparam int WordW      = 64;

   typedef enum logic [1:0] {
      CMD_BASE  = 2'd0,
      CMD_DUMP  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   localparam logic [7:0] FoldMask = 8'hDF;
   localparam logic [7:0] QualLo   = 8'h21;
   localparam logic [7:0] QualHi   = 8'h7E;
   localparam logic [7:0] Q20Char  = 8'h35;
   localparam logic [7:0] Q30Char  = 8'h3F;
   localparam logic [7:0] Q40Char  = 8'h49;

   // one-hot class: a,c,g,t,n,other from bit 0 up
   function automatic logic [5:0] base_class(input logic [7:0] b);
      logic [7:0] up;
      logic [5:0] r;
      up = b & FoldMask;
      r  = 6'b0;
      r[0] = (up == 8'h41);
      r[1] = (up == 8'h43);
      r[2] = (up == 8'h47);
      r[3] = (up == 8'h54);
      r[4] = (up == 8'h4E);
      r[5] = ~|r[4:0];
      return r;
   endfunction

endpackage

>>> sv/fqc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module fqc_ram #(
   parameter int Width = 64,
   parameter int Depth = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> sv/fastq_read_and_cycle_qc.sv
// FASTQ per-base statistics: read totals in registers, per-position table in RAM.
// Depends on fqc_pkg and fqc_ram.
//
// One request is accepted per cycle while neither the clearing pass nor a
// result run holds input off. For a base without last_base the position row
// (11 words of 64 bits, 704 bits wide in one RAM) is read, updated in the next
// cycle and written back, with forwarding when consecutive requests touch the
// same row. A last base or a dump yields a run of 12 or 11 result words, one
// per cycle while rsp_tready is high; the first word follows once the request
// has passed stage 1 and the run registers are loaded. Input is held off in
// the stage cycle that loads the run and while the run drains, and rsp_tready
// low lengthens the drain. After reset a clearing pass zeroes all 512 table
// rows before the first request is taken.
module fastq_read_and_cycle_qc
   import fqc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: cmd[1:0], base_char[9:2], quality_char[17:10],
   //        entry_position[26:18], zero fill
   input  logic [31:0] req_tdata,
   input  logic        req_tlast,  // last_base
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: word_index[3:0], word_value[67:4], zero fill
   output logic [71:0] rsp_tdata,
   output logic        rsp_tuser,  // source
   output logic        rsp_tlast   // last_word
);
   localparam int RowW = TblWords * WordW;

   typedef logic [WordW-1:0] word_type;

   // stage 1 (after acceptance)
   logic               s1_ff, s1_in;
   cmd_type            s1_cmd_ff;
   logic [7:0]         s1_b_ff, s1_q_ff;
   logic               s1_last_ff;
   logic [PosW-1:0]    s1_pos_ff;
   logic               s1_tbl_ff;       // base goes to the table
   logic               s1_ok_ff;        // base counts at all

   // read state
   logic [RpW-1:0]     rpos_ff;
   word_type           tot_ff [10];
   logic               qerr_ff, ovf_ff;

   // clear sweep
   logic               clr_ff;
   logic [PosW-1:0]    clr_addr_ff;

   // output run
   logic               busy_ff;
   logic               src_ff;
   logic [3:0]         idx_ff;
   logic [3:0]         lastidx_ff;
   word_type           run_ff [ReadWords];

   // forwarding of the last written row
   logic               wb_ff;
   logic [PosW-1:0]    wb_addr_ff;
   logic [RowW-1:0]    wb_row_ff;

   logic               ram_we;
   logic [PosW-1:0]    ram_wa, ram_ra;
   logic [RowW-1:0]    ram_wd, ram_rd, row;

   logic               acc;
   cmd_type            in_cmd;
   logic [7:0]         in_b, in_q;
   logic [PosW-1:0]    in_pos;
   logic               qok;
   logic [5:0]         cls;
   logic [6:0]         phred;
   logic               in_ok;
   logic               in_tbl;

   assign in_cmd = cmd_type'(req_tdata[1:0]);
   assign in_b   = req_tdata[9:2];
   assign in_q   = req_tdata[17:10];
   assign in_pos = req_tdata[26:18];

   // stall while clearing, while a run is pending or when one begins next cycle
   assign req_tready = !clr_ff && !busy_ff &&
      !(s1_ff && ((s1_cmd_ff == CMD_BASE && s1_last_ff) || s1_cmd_ff == CMD_DUMP));
   assign acc = req_tvalid && req_tready;

   // read flags seen by the incoming base, including the one in stage 1
   logic qerr_eff, rpos_sat;
   logic [RpW-1:0] rpos_eff;
   logic s1_qbad;
   assign s1_qbad  = (s1_q_ff < QualLo) || (s1_q_ff > QualHi);
   assign qerr_eff = qerr_ff || (s1_ff && s1_cmd_ff == CMD_BASE && s1_qbad && !s1_last_ff);
   assign rpos_eff = (s1_ff && s1_cmd_ff == CMD_BASE && s1_last_ff) ? '0 :
                     (s1_ff && s1_cmd_ff == CMD_BASE && s1_tbl_ff) ? rpos_ff + 1'b1 :
                     rpos_ff;
   assign rpos_sat = rpos_eff[RpW-1];
   assign qok      = (in_q >= QualLo) && (in_q <= QualHi);
   assign in_ok    = !qerr_eff && qok;
   assign in_tbl   = in_ok && !rpos_sat;

   assign ram_ra = (in_cmd == CMD_BASE) ? rpos_eff[PosW-1:0] : in_pos;

   fqc_ram #(.Width(RowW), .Depth(MaxReadLen)) u_tbl (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wa),
      .wr_data(ram_wd),
      .rd_addr(ram_ra),
      .rd_data(ram_rd)
   );

   assign row = (wb_ff && wb_addr_ff == s1_pos_ff) ? wb_row_ff : ram_rd;

   assign cls   = base_class(s1_b_ff);
   assign phred = 7'(s1_q_ff - QualLo);

   logic [RowW-1:0] upd_row;
   always_comb begin
      word_type w [TblWords];
      for (int k = 0; k < TblWords; k++) begin
         w[k] = row[k*WordW +: WordW];
      end
      for (int k = 0; k < 6; k++) begin
         w[k] = w[k] + word_type'(cls[k]);
      end
      w[6] = w[6] + word_type'(phred);
      for (int k = 0; k < 4; k++) begin
         w[7+k] = w[7+k] + (cls[k] ? word_type'(phred) : '0);
      end
      for (int k = 0; k < TblWords; k++) begin
         upd_row[k*WordW +: WordW] = w[k];
      end
   end

   always_comb begin
      ram_we = 1'b0;
      ram_wa = s1_pos_ff;
      ram_wd = upd_row;
      if (clr_ff) begin
         ram_we = 1'b1;
         ram_wa = clr_addr_ff;
         ram_wd = '0;
      end else if (s1_ff && s1_cmd_ff == CMD_BASE && s1_tbl_ff) begin
         ram_we = 1'b1;
      end else if (s1_ff && s1_cmd_ff == CMD_CLEAR) begin
         ram_we = 1'b1;
         ram_wd = '0;
      end
   end

   assign s1_in = acc && in_cmd != CMD_NONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff       <= 1'b0;
         rpos_ff     <= '0;
         qerr_ff     <= 1'b0;
         ovf_ff      <= 1'b0;
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
         busy_ff     <= 1'b0;
         wb_ff       <= 1'b0;
         idx_ff      <= '0;
         for (int k = 0; k < 10; k++) begin
            tot_ff[k] <= '0;
         end
      end else begin
         s1_ff <= s1_in;
         if (clr_ff) begin
            clr_addr_ff <= clr_addr_ff + 1'b1;
            if (&clr_addr_ff) begin
               clr_ff <= 1'b0;
            end
         end
         wb_ff <= ram_we && !clr_ff;
         // advance output run
         if (busy_ff && rsp_tready) begin
            idx_ff <= idx_ff + 1'b1;
            if (idx_ff == lastidx_ff) begin
               busy_ff <= 1'b0;
            end
         end
         if (s1_ff && s1_cmd_ff == CMD_BASE) begin
            if (s1_last_ff) begin
               rpos_ff <= '0;
               qerr_ff <= 1'b0;
               ovf_ff  <= 1'b0;
               for (int k = 0; k < 10; k++) begin
                  tot_ff[k] <= '0;
               end
               busy_ff    <= 1'b1;
               idx_ff     <= '0;
            end else begin
               if (s1_tbl_ff) begin
                  rpos_ff <= rpos_ff + 1'b1;
               end
               if (!s1_ok_ff && !qerr_ff) begin
                  qerr_ff <= 1'b1;
               end
               if (s1_ok_ff && !s1_tbl_ff) begin
                  ovf_ff <= 1'b1;
               end
               if (s1_ok_ff) begin
                  for (int k = 0; k < 6; k++) begin
                     tot_ff[k] <= tot_ff[k] + word_type'(cls[k]);
                  end
                  tot_ff[6] <= tot_ff[6] + word_type'(phred);
                  tot_ff[7] <= tot_ff[7] + word_type'(s1_q_ff >= Q20Char);
                  tot_ff[8] <= tot_ff[8] + word_type'(s1_q_ff >= Q30Char);
                  tot_ff[9] <= tot_ff[9] + word_type'(s1_q_ff >= Q40Char);
               end
            end
         end
         if (s1_ff && s1_cmd_ff == CMD_DUMP) begin
            busy_ff <= 1'b1;
            idx_ff  <= '0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (acc) begin
         s1_cmd_ff  <= in_cmd;
         s1_b_ff    <= in_b;
         s1_q_ff    <= in_q;
         s1_last_ff <= req_tlast;
         s1_pos_ff  <= ram_ra;
         s1_ok_ff   <= in_ok;
         s1_tbl_ff  <= in_tbl;
      end
      wb_addr_ff <= ram_wa;
      wb_row_ff  <= ram_wd;
      if (s1_ff && s1_cmd_ff == CMD_BASE && s1_last_ff) begin
         src_ff     <= 1'b0;
         lastidx_ff <= 4'(ReadWords - 1);
         // fold in the final base itself
         for (int k = 0; k < 6; k++) begin
            run_ff[k] <= tot_ff[k] + word_type'(s1_ok_ff && cls[k]);
         end
         run_ff[6] <= tot_ff[6] + (s1_ok_ff ? word_type'(phred) : '0);
         run_ff[7] <= tot_ff[7] + word_type'(s1_ok_ff && s1_q_ff >= Q20Char);
         run_ff[8] <= tot_ff[8] + word_type'(s1_ok_ff && s1_q_ff >= Q30Char);
         run_ff[9] <= tot_ff[9] + word_type'(s1_ok_ff && s1_q_ff >= Q40Char);
         run_ff[10] <= word_type'(qerr_ff || !s1_ok_ff);
         run_ff[11] <= word_type'(ovf_ff || (s1_ok_ff && !s1_tbl_ff));
      end else if (s1_ff && s1_cmd_ff == CMD_DUMP) begin
         src_ff     <= 1'b1;
         lastidx_ff <= 4'(TblWords - 1);
         for (int k = 0; k < TblWords; k++) begin
            run_ff[k] <= row[k*WordW +: WordW];
         end
         run_ff[11] <= '0;
      end
   end

   assign rsp_tvalid = busy_ff;
   assign rsp_tdata  = {4'b0, run_ff[idx_ff], idx_ff};
   assign rsp_tuser  = src_ff;
   assign rsp_tlast  = (idx_ff == lastidx_ff);
endmodule
